FILE: sv/kvkt_pkg.sv
// shared types and constants for the key table engine
package kvkt_pkg;
  localparam logic [2:0] ACT_STORE = 3'd0;
  localparam logic [2:0] ACT_RETRIEVE = 3'd1;
  localparam logic [2:0] ACT_DELETE = 3'd2;
  localparam logic [2:0] ACT_EXIST = 3'd3;
  localparam logic [2:0] ACT_LIST = 3'd4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_KEYSZ = 3'd1;
  localparam logic [2:0] ST_VALSZ = 3'd2;
  localparam logic [2:0] ST_EXISTS = 3'd3;
  localparam logic [2:0] ST_ABSENT = 3'd4;
  localparam logic [2:0] ST_INVAL = 3'd5;
  localparam logic [2:0] ST_FULL = 3'd6;

  localparam int KEY_MAX = 16;
  localparam int LIST_HDR = 4;
  localparam int MAX_RECORDS = 16;
  localparam int IN_W = 176;
  localparam int OUT_W = 176;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot_index;
    logic [12:0] transfer_length;
    logic [4:0] entries_used;
    logic [4:0] listed_key_length;
    logic [63:0] listed_key_low;
    logic [63:0] listed_key_high;
    logic [12:0] record_offset;
    logic [4:0] keys_listed;
    logic last_result;
  } result_t;

  // 128-bit mask of the first n key bytes
  function automatic logic [127:0] key_mask(input logic [4:0] n);
    logic [127:0] m;
    m = '0;
    for (int i = 0; i < KEY_MAX; i++) begin
      if (i < n) m[i*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

  // packs a result into the output data word, first field lowest
  function automatic logic [OUT_W-1:0] pack_result(input result_t r);
    logic [OUT_W-1:0] d;
    d = '0;
    d[2:0] = r.status;
    d[6:3] = r.slot_index;
    d[19:7] = r.transfer_length;
    d[24:20] = r.entries_used;
    d[29:25] = r.listed_key_length;
    d[93:30] = r.listed_key_low;
    d[157:94] = r.listed_key_high;
    d[170:158] = r.record_offset;
    d[175:171] = r.keys_listed;
    return d;
  endfunction
endpackage

FILE: sv/kvkt_slot_cmp.sv
// shared slot compare unit: one table slot per cycle against the command key
module kvkt_slot_cmp (
  input  logic         slot_valid,
  input  logic [4:0]   slot_len,
  input  logic [127:0] slot_key,
  input  logic [4:0]   key_len,
  input  logic [127:0] key_masked,
  output logic         hit
);
  import kvkt_pkg::*;
  assign hit = slot_valid && (slot_len == key_len) &&
               (((slot_key ^ key_masked) & key_mask(key_len)) == '0);
endmodule

FILE: sv/kv_key_table_engine.sv
// top level of the key table engine: sequencer, slot table and output register
// a command runs a lookup scan over every slot, then for a store a free-slot
// scan or for a list a list scan, and emits one result per output transfer;
// the single slot compare unit checks one slot a cycle during the lookup scan
// reset: rst (synchronous) clears valid bits, used count and register; key
// storage keeps its contents
module kv_key_table_engine #(
  parameter int TABLE_ENTRIES = 16,
  parameter int MAX_VALUE_BYTES = 4096
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  input  logic s_tvalid,
  output logic s_tready,
  // action, key_length, key_low_bytes, key_high_bytes, host_bytes,
  // only_if_absent, only_if_present (lowest first)
  input  logic [kvkt_pkg::IN_W-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // status, slot_index, transfer_length, entries_used, listed_key_length,
  // listed_key_low, listed_key_high, record_offset, keys_listed (lowest first)
  output logic [kvkt_pkg::OUT_W-1:0] m_tdata,
  output logic m_tlast
);
  import kvkt_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int HBW = 32;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MATCH = 3'd1;
  localparam logic [2:0] S_FREE = 3'd2;
  localparam logic [2:0] S_LIST = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;

  logic [2:0] state;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [4:0] klen_mem [TABLE_ENTRIES];
  logic [127:0] key_mem [TABLE_ENTRIES];
  logic [CW-1:0] used;
  logic del_missing;

  // command registers
  logic [2:0] act;
  logic [4:0] klen;
  logic [127:0] key;
  logic [HBW-1:0] hbs;
  logic opt_absent, opt_present;

  logic [CW-1:0] idx;
  logic found;
  logic [IW-1:0] match_idx;
  logic [15:0] total;
  logic [4:0] listed;

  logic out_valid;
  result_t out_r;
  logic out_last;

  logic [IW-1:0] idx_s;
  logic hit;
  logic [7:0] in_klen;
  logic [127:0] in_key_masked;

  assign idx_s = idx[IW-1:0];
  assign in_klen = s_tdata[10:3];
  assign in_key_masked = {s_tdata[138:75], s_tdata[74:11]} &
                         key_mask(in_klen[4:0]);

  kvkt_slot_cmp u_cmp (
    .slot_valid(valid[idx_s]),
    .slot_len(klen_mem[idx_s]),
    .slot_key(key_mem[idx_s]),
    .key_len(klen),
    .key_masked(key),
    .hit(hit)
  );

  assign s_tready = (state == S_IDLE) && !out_valid;
  assign m_tvalid = out_valid;
  assign m_tdata = pack_result(out_r);
  assign m_tlast = out_last;

  // record size: 2 + key length rounded up to a multiple of four
  logic [5:0] rec_sz;
  logic [15:0] rec_end;
  assign rec_sz = (6'd5 + {1'b0, klen_mem[idx_s]}) & 6'b111100;
  assign rec_end = total + {10'd0, rec_sz};

  function automatic result_t mk(input logic [2:0] st, input logic [3:0] sl,
                                 input logic [12:0] xf, input logic [4:0] eu);
    result_t r;
    r = '0;
    r.status = st;
    r.slot_index = sl;
    r.transfer_length = xf;
    r.entries_used = eu;
    r.last_result = 1'b1;
    return r;
  endfunction

  // one list record transaction
  function automatic result_t mk_rec(input logic [3:0] sl, input logic [4:0] eu,
                                     input logic [4:0] kl, input logic [127:0] kb,
                                     input logic [12:0] off);
    result_t r;
    r = '0;
    r.status = ST_OK;
    r.slot_index = sl;
    r.entries_used = eu;
    r.listed_key_length = kl;
    r.listed_key_low = kb[63:0];
    r.listed_key_high = kb[127:64];
    r.record_offset = off;
    r.last_result = 1'b0;
    return r;
  endfunction

  // final list transaction with byte total and key count
  function automatic result_t mk_done(input logic [12:0] xf, input logic [4:0] eu,
                                      input logic [4:0] cnt);
    result_t r;
    r = '0;
    r.status = ST_OK;
    r.transfer_length = xf;
    r.entries_used = eu;
    r.keys_listed = cnt;
    r.last_result = 1'b1;
    return r;
  endfunction

  logic [4:0] used5;
  assign used5 = 5'(used);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      used <= '0;
      del_missing <= 1'b0;
      out_valid <= 1'b0;
      out_last <= 1'b0;
    end else begin
      if (cfg_we) del_missing <= cfg_wdata;
      if (out_valid && m_tready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            act <= s_tdata[2:0];
            klen <= in_klen[4:0];
            key <= in_key_masked;
            hbs <= s_tdata[170:139];
            opt_absent <= s_tdata[171];
            opt_present <= s_tdata[172];
            idx <= '0;
            found <= 1'b0;
            match_idx <= '0;
            if (s_tdata[2:0] > ACT_LIST) begin
              out_r <= mk(ST_INVAL, 4'd0, 13'd0, used5);
              out_last <= 1'b1;
              out_valid <= 1'b1;
            end else if (in_klen > 8'(KEY_MAX)) begin
              out_r <= mk((s_tdata[2:0] == ACT_STORE) ? ST_KEYSZ : ST_INVAL,
                          4'd0, 13'd0, used5);
              out_last <= 1'b1;
              out_valid <= 1'b1;
            end else if (s_tdata[2:0] == ACT_STORE &&
                         s_tdata[170:139] > 32'(MAX_VALUE_BYTES)) begin
              out_r <= mk(ST_VALSZ, 4'd0, 13'd0, used5);
              out_last <= 1'b1;
              out_valid <= 1'b1;
            end else begin
              state <= S_MATCH;
            end
          end
        end
        S_MATCH: begin
          if (hit && !found) begin
            found <= 1'b1;
            match_idx <= idx_s;
          end
          if (idx == CW'(TABLE_ENTRIES - 1)) state <= S_DECIDE;
          else idx <= idx + 1'b1;
        end
        S_DECIDE: begin
          idx <= '0;
          case (act)
            ACT_STORE: begin
              if (found) begin
                out_r <= opt_absent ? mk(ST_EXISTS, 4'd0, 13'd0, used5)
                       : mk(ST_OK, 4'(match_idx), 13'(hbs), used5);
                out_last <= 1'b1;
                out_valid <= 1'b1;
                state <= S_IDLE;
              end else if (opt_present) begin
                out_r <= mk(ST_ABSENT, 4'd0, 13'd0, used5);
                out_last <= 1'b1;
                out_valid <= 1'b1;
                state <= S_IDLE;
              end else begin
                state <= S_FREE;
              end
            end
            ACT_RETRIEVE: begin
              out_r <= found ? mk(ST_OK, 4'(match_idx),
                         (hbs < 32'(MAX_VALUE_BYTES)) ? 13'(hbs)
                         : 13'(MAX_VALUE_BYTES), used5)
                       : mk(ST_ABSENT, 4'd0, 13'd0, used5);
              out_last <= 1'b1;
              out_valid <= 1'b1;
              state <= S_IDLE;
            end
            ACT_DELETE: begin
              if (found) begin
                valid[match_idx] <= 1'b0;
                used <= used - 1'b1;
                out_r <= mk(ST_OK, 4'(match_idx), 13'd0, 5'(used - 1'b1));
              end else begin
                out_r <= mk(del_missing ? ST_ABSENT : ST_OK, 4'd0, 13'd0, used5);
              end
              out_last <= 1'b1;
              out_valid <= 1'b1;
              state <= S_IDLE;
            end
            ACT_EXIST: begin
              out_r <= found ? mk(ST_OK, 4'(match_idx), 13'd0, used5)
                       : mk(ST_ABSENT, 4'd0, 13'd0, used5);
              out_last <= 1'b1;
              out_valid <= 1'b1;
              state <= S_IDLE;
            end
            default: begin
              // list starts at the matching slot, or slot zero
              idx <= found ? CW'(match_idx) : '0;
              total <= 16'(LIST_HDR);
              listed <= '0;
              state <= S_LIST;
            end
          endcase
        end
        S_FREE: begin
          if (!valid[idx_s]) begin
            valid[idx_s] <= 1'b1;
            klen_mem[idx_s] <= klen;
            key_mem[idx_s] <= key;
            used <= used + 1'b1;
            out_r <= mk(ST_OK, 4'(idx_s), 13'(hbs), 5'(used + 1'b1));
            out_last <= 1'b1;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else if (idx == CW'(TABLE_ENTRIES - 1)) begin
            out_r <= mk(ST_FULL, 4'd0, 13'd0, used5);
            out_last <= 1'b1;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_LIST: begin
          // waits for the output register before each step
          if (!out_valid) begin
            if (idx >= CW'(TABLE_ENTRIES) || listed == 5'(MAX_RECORDS) ||
                (valid[idx_s] && {16'd0, rec_end} > {16'd0, hbs})) begin
              state <= S_EMIT;
            end else begin
              if (valid[idx_s]) begin
                out_r <= mk_rec(4'(idx_s), used5, klen_mem[idx_s], key_mem[idx_s],
                                13'(total));
                out_last <= 1'b0;
                out_valid <= 1'b1;
                total <= rec_end;
                listed <= listed + 1'b1;
              end
              idx <= idx + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid) begin
            out_r <= mk_done(13'(total), used5, listed);
            out_last <= 1'b1;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: sv/kvkt_checker.sv
// port-level checker for the key table engine and its bind
module kvkt_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [kvkt_pkg::OUT_W-1:0] m_tdata,
  input logic m_tlast
);
  import kvkt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");
  a_noaccept: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken while a result waits");
  a_used: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[24:20] <= 5'd16)
    else $error("entries used out of range");
  a_rec_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[2:0] == ST_OK)
    else $error("list record with error status");
endmodule

bind kv_key_table_engine kvkt_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
